// File: sv/csfw_pkg.sv
// Shared types and constants for the counting semaphore bank with FIFO waiters.
// Used by the step unit, the top level and the checker; has no dependencies of its own.
`default_nettype none

package csfw_pkg;

  // Bank geometry and limits.
  localparam int NUM_SEMS    = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_COUNT   = 127;
  localparam int THREAD_BITS = 8;
  localparam int MAX_REPEAT  = 16;

  // Field widths fixed by the interface.
  localparam int SEM_W    = 4;
  localparam int QPTR_W   = 4;
  localparam int COUNT_W  = 8;
  localparam int REP_W    = 5;
  localparam int EVENT_W  = 3;
  localparam int WADDR_W  = SEM_W + QPTR_W;
  localparam int WDEPTH   = NUM_SEMS * QUEUE_DEPTH;

  localparam logic signed [COUNT_W-1:0] CNT_MAX  = COUNT_W'(MAX_COUNT);
  localparam logic signed [COUNT_W-1:0] CNT_FULL = -COUNT_W'(QUEUE_DEPTH);
  localparam logic [REP_W-1:0]          REP_MAX  = REP_W'(MAX_REPEAT);

  typedef enum logic {
    CMD_WAIT   = 1'b0,
    CMD_SIGNAL = 1'b1
  } cmd_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_GRANTED   = 3'd0,
    EV_BLOCKED   = 3'd1,
    EV_WOKEN     = 3'd2,
    EV_RAISED    = 3'd3,
    EV_FULL      = 3'd4,
    EV_SATURATED = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  // Operands handed to the step unit for one semaphore operation.
  typedef struct packed {
    cmd_e                       cmd;
    logic signed [COUNT_W-1:0]  count;
    logic [QPTR_W-1:0]          head;
    logic [THREAD_BITS-1:0]     thread;
    logic [THREAD_BITS-1:0]     woken;
  } step_req_t;

  // Outcome of one step: new state of the semaphore and the result beat.
  typedef struct packed {
    event_e                     event_res;
    logic [THREAD_BITS-1:0]     thread;
    logic signed [COUNT_W-1:0]  count_next;
    logic [QPTR_W-1:0]          head_next;
    logic                       wr_en;
    logic [QPTR_W-1:0]          wr_slot;
  } step_res_t;

endpackage

`default_nettype wire

// File: sv/csfw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the waiter queue storage.
`default_nettype none

module csfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/csfw_step.sv
// Shared step unit: one count adder and the compares that pick the event.
// Depends on csfw_pkg for the request and result structs.
`default_nettype none

module csfw_step (
  input  wire csfw_pkg::step_req_t req_i,
  output csfw_pkg::step_res_t      res_o
);

  import csfw_pkg::*;

  logic signed [COUNT_W-1:0] delta;
  logic signed [COUNT_W-1:0] sum;

  // The single adder moves the count by one in either direction.
  assign delta = (req_i.cmd == CMD_SIGNAL) ? COUNT_W'(1) : -COUNT_W'(1);
  assign sum   = req_i.count + delta;

  // Decide the event and the new semaphore state.
  always_comb begin
    res_o            = '0;
    res_o.thread     = req_i.thread;
    res_o.count_next = req_i.count;
    res_o.head_next  = req_i.head;
    // The tail slot is head plus the number of waiters, which is minus the count.
    res_o.wr_slot    = req_i.head - req_i.count[QPTR_W-1:0];
    res_o.wr_en      = 1'b0;
    res_o.event_res  = EV_GRANTED;
    if (req_i.cmd == CMD_WAIT) begin
      if (req_i.count > 0) begin
        res_o.event_res  = EV_GRANTED;
        res_o.count_next = sum;
      end else if (req_i.count <= CNT_FULL) begin
        res_o.event_res  = EV_FULL;
      end else begin
        res_o.event_res  = EV_BLOCKED;
        res_o.count_next = sum;
        res_o.wr_en      = 1'b1;
      end
    end else begin
      if (req_i.count < 0) begin
        res_o.event_res  = EV_WOKEN;
        res_o.thread     = req_i.woken;
        res_o.head_next  = req_i.head + QPTR_W'(1);
        res_o.count_next = sum;
      end else if (req_i.count >= CNT_MAX) begin
        res_o.event_res  = EV_SATURATED;
      end else begin
        res_o.event_res  = EV_RAISED;
        res_o.count_next = sum;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/counting_semaphore_fifo_waiters_core.sv
// Top level of the counting semaphore bank with FIFO wait queues.
// Depends on csfw_pkg, csfw_step and csfw_ram.
`default_nettype none

// A bank of 16 counting semaphores, each with a 16-entry FIFO of waiting
// thread identifiers kept in one 256-entry RAM. A wait beat yields one result;
// a signal beat yields signal_count results (0 is taken as 1, above 16 as 16),
// and the final result of every input beat has last_o set. The block takes one
// input beat at a time: it is accepted in the idle cycle, then every operation
// step reads the queue head from the RAM (registered read) and then lets the
// shared count adder update the semaphore and load the output register. The
// update step waits while a stalled result beat still holds the output
// register. No clearing pass follows reset.
module counting_semaphore_fifo_waiters_core (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      in_valid_i,
  output logic                                           in_stall_o,
  input  wire logic                                      cmd_i,
  input  wire logic [csfw_pkg::SEM_W-1:0]                sem_index_i,
  input  wire logic [csfw_pkg::THREAD_BITS-1:0]          thread_id_i,
  input  wire logic [csfw_pkg::REP_W-1:0]                signal_count_i,
  output logic                                           out_valid_o,
  input  wire logic                                      out_stall_i,
  output logic      [csfw_pkg::EVENT_W-1:0]              event_res_o,
  output logic      [csfw_pkg::THREAD_BITS-1:0]          event_thread_o,
  output logic      [csfw_pkg::SEM_W-1:0]                event_sem_o,
  output logic signed [csfw_pkg::COUNT_W-1:0]            new_count_o,
  output logic                                           last_o
);

  import csfw_pkg::*;

  state_e state_q, state_d;

  // Operation held for the duration of one input beat.
  cmd_e                     cmd_q;
  logic [SEM_W-1:0]         sem_q;
  logic [THREAD_BITS-1:0]   thread_q;
  logic [REP_W-1:0]         reps_q, reps_d;

  // Per-semaphore state.
  logic signed [COUNT_W-1:0] counts_q [NUM_SEMS];
  logic [QPTR_W-1:0]         heads_q  [NUM_SEMS];

  // Output register.
  logic                      out_valid_q;
  logic [EVENT_W-1:0]        event_q;
  logic [THREAD_BITS-1:0]    ev_thread_q;
  logic [SEM_W-1:0]          ev_sem_q;
  logic signed [COUNT_W-1:0] ev_count_q;
  logic                      ev_last_q;

  logic                    in_fire;
  logic                    out_free;
  logic                    step_fire;
  logic                    step_last;
  logic                    ram_re;
  logic                    ram_we;
  logic [THREAD_BITS-1:0]  ram_rdata;
  logic [REP_W-1:0]        reps_in;
  step_req_t               req;
  step_res_t               res;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_fire = (state_q == ST_EXEC) && out_free;
  assign step_last = (cmd_q == CMD_WAIT) || (reps_q == REP_W'(1));

  // Repetition count clamped to the legal range.
  always_comb begin
    reps_in = signal_count_i;
    if (signal_count_i == '0) begin
      reps_in = REP_W'(1);
    end else if (signal_count_i > REP_MAX) begin
      reps_in = REP_MAX;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = step_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    reps_d     = reps_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_EXEC: begin
        ram_we = out_free && res.wr_en;
        if (out_free) begin
          reps_d = reps_q - REP_W'(1);
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the operation of an accepted input beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= cmd_e'(cmd_i);
      sem_q    <= sem_index_i;
      thread_q <= thread_id_i;
      reps_q   <= (cmd_e'(cmd_i) == CMD_WAIT) ? REP_W'(1) : reps_in;
    end else begin
      reps_q   <= reps_d;
    end
  end

  // Operands for the shared step unit.
  always_comb begin
    req.cmd    = cmd_q;
    req.count  = counts_q[sem_q];
    req.head   = heads_q[sem_q];
    req.thread = thread_q;
    req.woken  = ram_rdata;
  end

  csfw_step u_step (
    .req_i (req),
    .res_o (res)
  );

  csfw_ram #(
    .WIDTH (THREAD_BITS),
    .DEPTH (WDEPTH)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({sem_q, res.wr_slot}),
    .wdata_i (thread_q),
    .re_i    (ram_re),
    .raddr_i ({sem_q, heads_q[sem_q]}),
    .rdata_o (ram_rdata)
  );

  // Semaphore counts and queue heads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        counts_q[i] <= '0;
        heads_q[i]  <= '0;
      end
    end else if (step_fire) begin
      counts_q[sem_q] <= res.count_next;
      heads_q[sem_q]  <= res.head_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      event_q     <= res.event_res;
      ev_thread_q <= res.thread;
      ev_sem_q    <= sem_q;
      ev_count_q  <= res.count_next;
      ev_last_q   <= step_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = event_q;
  assign event_thread_o = ev_thread_q;
  assign event_sem_o    = ev_sem_q;
  assign new_count_o    = ev_count_q;
  assign last_o         = ev_last_q;

endmodule

`default_nettype wire

// File: sv/csfw_checker.sv
// Port-level checker for the semaphore bank top level, with its bind.
// Depends on csfw_pkg for widths and event codes.
`default_nettype none

module csfw_checker (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   in_valid_i,
  input wire logic                                   in_stall_o,
  input wire logic                                   out_valid_o,
  input wire logic                                   out_stall_i,
  input wire logic [csfw_pkg::EVENT_W-1:0]           event_res_o,
  input wire logic [csfw_pkg::THREAD_BITS-1:0]       event_thread_o,
  input wire logic [csfw_pkg::SEM_W-1:0]             event_sem_o,
  input wire logic signed [csfw_pkg::COUNT_W-1:0]    new_count_o,
  input wire logic                                   last_o
);

  import csfw_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o)
      && $stable(event_thread_o) && $stable(event_sem_o) && $stable(new_count_o)
      && $stable(last_o))
    else $error("stalled result beat changed");

  // The block is busy in the cycle after it takes an input beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an operation is in progress");

  // A granted wait leaves a non-negative count; a blocked wait a negative one.
  a_wait_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o != EV_GRANTED || new_count_o >= 0)
      && (event_res_o != EV_BLOCKED || new_count_o < 0))
    else $error("wait result disagrees with the count sign");

  // Saturation is reported only at the maximum count.
  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_SATURATED |-> new_count_o == CNT_MAX)
    else $error("saturation reported below the maximum count");

  // A wake-up never leaves the count positive.
  a_woken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_WOKEN |-> new_count_o <= 0)
    else $error("woken thread reported with a positive count");

endmodule

bind counting_semaphore_fifo_waiters_core csfw_checker u_csfw_checker (.*);

`default_nettype wire
